// ----- hw/rtl/irsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsb_pkg
// Shared widths, register codes and helpers for the IR slope beam detector.
// ----------------------------------------------------------------------------
package irsb_pkg;

  // Number of sensor channels and converter sample width.
  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 12;

  // Beat field widths.
  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W  = 12;
  localparam int KEY_W     = 6;
  localparam int CSUM_W    = 8;

  // Per-channel state widths.
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CNT_W  = CHANNEL_W + 1;
  localparam int SUM_W     = 16;
  localparam int SLOPE_W   = SAMPLE_BITS + 1;
  localparam int EXT_W     = ((SLOPE_W > SUM_W) ? SLOPE_W : SUM_W) + 1;
  localparam int CMP_W     = SUM_W + 1;

  // Saturation bounds of the slope accumulator.
  localparam int SUM_MAX = 2 ** (SUM_W - 1) - 1;
  localparam int SUM_MIN = -(2 ** (SUM_W - 1));
  localparam logic signed [EXT_W-1:0] SUM_MAX_X = EXT_W'(SUM_MAX);
  localparam logic signed [EXT_W-1:0] SUM_MIN_X = EXT_W'(SUM_MIN);

  // Configuration registers.
  localparam int CFG_W   = 12;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_SLIDE_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_REBASE_LIMIT    = 1'b1;
  localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(200);
  localparam logic [CFG_W-1:0] REBASE_RST    = CFG_W'(50);

  // Packet header bytes 0xff + 0x05 + 0x01.
  localparam logic [8:0] HEADER_SUM = 9'h105;

  // Clamp a widened sum to the signed accumulator range.
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [EXT_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > SUM_MAX_X) begin
      r = SUM_W'(SUM_MAX);
    end else if (v < SUM_MIN_X) begin
      r = SUM_W'(SUM_MIN);
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/irsb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsb_in_if / irsb_out_if
// Valid/ready channels for sensor sample beats and key report beats.
// ----------------------------------------------------------------------------

// Sample channel: one converter reading tagged with its sensor channel.
interface irsb_in_if;
  logic                           valid;
  logic                           ready;
  logic [irsb_pkg::CHANNEL_W-1:0] channel;
  logic [irsb_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// Report channel: key bitmap and packet checksum.
interface irsb_out_if;
  logic                        valid;
  logic                        ready;
  logic [irsb_pkg::KEY_W-1:0]  key_bitmap;
  logic [irsb_pkg::CSUM_W-1:0] packet_checksum;

  modport source (output valid, output key_bitmap, output packet_checksum, input ready);
  modport sink   (input valid, input key_bitmap, input packet_checksum, output ready);
endinterface

// ----- hw/rtl/ir_slope_beam_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_slope_beam_detector
// Throughput: one sample beat per cycle unless out_s.ready stalls the report beat; the per-channel add,
// clamp and threshold compare sit between the sample register and the report register.
// Reset: asynchronous, active low; clears all channel state and the bitmap,
// and loads threshold 200 and rebase limit 50. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ir_slope_beam_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  irsb_in_if.sink                        in_s,
  irsb_out_if.source                     out_s,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [irsb_pkg::PADDR_W-1:0]   paddr,
  input  logic [irsb_pkg::PDATA_W-1:0]   pwdata,
  output logic [irsb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // Configuration registers.
  logic [irsb_pkg::CFG_W-1:0] thr_q;
  logic [irsb_pkg::CFG_W-1:0] lim_q;
  logic                       cfg_we;
  logic [0:0]                 cfg_sel;

  // Sample register stage.
  logic                             s1_valid_q;
  logic [irsb_pkg::CHANNEL_W-1:0]   s1_channel_q;
  logic [irsb_pkg::SAMPLE_W-1:0]    s1_sample_q;
  logic                             s1_adv;

  // Per-channel state.
  logic [irsb_pkg::SAMPLE_BITS-1:0]  prev_q   [irsb_pkg::CHANNELS];
  logic signed [irsb_pkg::SUM_W-1:0] sum_q    [irsb_pkg::CHANNELS];
  logic [irsb_pkg::CHANNELS-1:0]     primed_q;
  logic [irsb_pkg::CHANNELS-1:0]     beam_q;
  logic [irsb_pkg::CHANNELS-1:0]     beam_d;

  // Datapath.
  logic                              in_range;
  logic                              upd;
  logic [irsb_pkg::CH_IDX_W-1:0]     idx;
  logic [irsb_pkg::CHANNELS-1:0]     ch_mask;
  logic [irsb_pkg::SAMPLE_BITS-1:0]  smp;
  logic signed [irsb_pkg::SLOPE_W-1:0] slope;
  logic signed [irsb_pkg::EXT_W-1:0] slope_x;
  logic signed [irsb_pkg::EXT_W-1:0] sum_x;
  logic signed [irsb_pkg::EXT_W-1:0] limit_x;
  logic signed [irsb_pkg::SUM_W-1:0] acc_add;
  logic signed [irsb_pkg::SUM_W-1:0] acc_new;
  logic signed [irsb_pkg::CMP_W-1:0] acc_c;
  logic signed [irsb_pkg::CMP_W-1:0] thr_c;

  // Report register.
  logic                        r_valid_q;
  logic [irsb_pkg::KEY_W-1:0]  r_key_q;
  logic [irsb_pkg::KEY_W-1:0]  r_key_d;
  logic [irsb_pkg::CSUM_W-1:0] r_csum_q;
  logic [irsb_pkg::CSUM_W-1:0] r_csum_d;

  // APB register write and read-back.
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= irsb_pkg::THRESHOLD_RST;
      lim_q <= irsb_pkg::REBASE_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        irsb_pkg::REG_SLIDE_THRESHOLD: thr_q <= pwdata[irsb_pkg::CFG_W-1:0];
        irsb_pkg::REG_REBASE_LIMIT:    lim_q <= pwdata[irsb_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      irsb_pkg::REG_SLIDE_THRESHOLD: prdata = irsb_pkg::PDATA_W'(thr_q);
      irsb_pkg::REG_REBASE_LIMIT:    prdata = irsb_pkg::PDATA_W'(lim_q);
      default:                       prdata = '0;
    endcase
  end

  // Handshake: the sample stage moves on when the report register is free or
  // being emptied in the same cycle.
  assign s1_adv     = s1_valid_q && (!r_valid_q || out_s.ready);
  assign in_s.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      s1_channel_q <= in_s.channel;
      s1_sample_q  <= in_s.sample;
    end
  end

  // Channel decode; out-of-range channels leave every state bit alone.
  assign in_range = {1'b0, s1_channel_q} < irsb_pkg::CH_CNT_W'(irsb_pkg::CHANNELS);
  assign idx      = s1_channel_q[irsb_pkg::CH_IDX_W-1:0];
  assign ch_mask  = in_range ? (irsb_pkg::CHANNELS'(1) << idx) : '0;
  assign upd      = s1_adv && in_range;
  assign smp      = irsb_pkg::SAMPLE_BITS'(s1_sample_q);

  // Slope, clamped accumulation and the two restart rules.
  always_comb begin
    slope   = $signed({1'b0, smp}) - $signed({1'b0, prev_q[idx]});
    slope_x = irsb_pkg::EXT_W'(slope);
    sum_x   = irsb_pkg::EXT_W'(sum_q[idx]) + slope_x;
    limit_x = $signed(irsb_pkg::EXT_W'(lim_q));
    acc_add = irsb_pkg::sat_sum(sum_x);
    acc_new = acc_add;
    if ((acc_add > 0) && (slope_x <= limit_x)) begin
      acc_new = irsb_pkg::sat_sum(slope_x);
    end else if ((acc_add < 0) && (slope_x >= limit_x)) begin
      acc_new = irsb_pkg::sat_sum(slope_x);
    end
  end

  // Threshold compare sets or clears the channel's beam bit.
  always_comb begin
    acc_c  = irsb_pkg::CMP_W'(acc_new);
    thr_c  = $signed(irsb_pkg::CMP_W'(thr_q));
    beam_d = beam_q;
    if (upd && primed_q[idx]) begin
      if (acc_c > thr_c) begin
        beam_d = beam_q | ch_mask;
      end else if (acc_c < -thr_c) begin
        beam_d = beam_q & ~ch_mask;
      end
    end
  end

  // Channel state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < irsb_pkg::CHANNELS; i++) begin
        prev_q[i] <= '0;
        sum_q[i]  <= '0;
      end
      primed_q <= '0;
      beam_q   <= '0;
    end else begin
      beam_q <= beam_d;
      if (upd) begin
        prev_q[idx]   <= smp;
        primed_q[idx] <= 1'b1;
        if (primed_q[idx]) begin
          sum_q[idx] <= acc_new;
        end
      end
    end
  end

  // Report beat: bitmap after this sample and its checksum.
  assign r_key_d  = irsb_pkg::KEY_W'(beam_d);
  assign r_csum_d = irsb_pkg::CSUM_W'(irsb_pkg::CSUM_W'(0)
                    - (irsb_pkg::CSUM_W'(r_key_d) + irsb_pkg::CSUM_W'(irsb_pkg::HEADER_SUM)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (s1_adv) begin
      r_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      r_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      r_key_q  <= r_key_d;
      r_csum_q <= r_csum_d;
    end
  end

  assign out_s.valid           = r_valid_q;
  assign out_s.key_bitmap      = r_key_q;
  assign out_s.packet_checksum = r_csum_q;

  // The header, bitmap and checksum of a report beat sum to zero.
  a_csum_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_q |-> (irsb_pkg::CSUM_W'(irsb_pkg::CSUM_W'(r_key_q) + r_csum_q
                   + irsb_pkg::CSUM_W'(irsb_pkg::HEADER_SUM)) == '0))
    else $error("report checksum does not match bitmap");

  // A sample only ever changes the beam bit of its own channel.
  a_beam_own_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> ((beam_q ^ $past(beam_q)) & ~$past(ch_mask)) == '0)
    else $error("beam bit of another channel changed");

  // A priming or out-of-range sample leaves the bitmap unchanged.
  a_prime_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (!in_range || !primed_q[idx])) |=> beam_q == $past(beam_q))
    else $error("bitmap changed on priming or out-of-range sample");

  // An empty sample stage always takes a new beat.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_s.ready)
    else $error("sample stage empty but not ready");

endmodule
